FILE: hw/rtl/nrmc_pkg.sv
// Shared types and constants for the RMC position parser.
// Holds the ASCII codes, the fix record passed from the parser to the
// converter, and the constant for the reciprocal divide by three.
`timescale 1ns / 1ps
`default_nettype none
package nrmc_pkg;

  // Sentence length limit; positions saturate here
  localparam int unsigned MAX_SENTENCE_LEN = 128;
  localparam int unsigned POS_W = 8;

  // Fix record queue between parser and converter
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  // floor(x*1000/60) = floor(x*50/3) = (x * 50 * ceil(2^27/3)) >> 27,
  // exact while 50*x < 2^27
  localparam logic [31:0] DIV3_K     = 32'd2236962150;
  localparam int unsigned DIV3_SHIFT = 27;

  typedef struct packed {
    logic        fix_valid;
    logic [19:0] time_acc;
    logic [6:0]  lat_deg;
    logic [6:0]  lat_min;
    logic [13:0] lat_frac;
    logic [9:0]  lon_deg;
    logic [6:0]  lon_min;
    logic [13:0] lon_frac;
    logic [7:0]  ns_letter;
    logic [7:0]  ew_letter;
  } fix_rec_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nrmc_front.sv
// Byte parser: tracks the sentence, checks the header's M and C letters,
// splits fields and collects digits. Pushes one fix record per completed
// RMC sentence within the length limit. Depends on nrmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrmc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_stall,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              q_full,
  output logic                   push,
  output nrmc_pkg::fix_rec_t     push_rec
);

  logic [nrmc_pkg::POS_W-1:0] sentence_pos;
  logic        header_ok;
  logic        overflowed;
  logic [2:0]  field_index;
  logic [3:0]  char_in_field;
  logic [19:0] time_acc;
  logic        status_valid;
  logic [6:0]  lat_deg_acc;
  logic [6:0]  lat_min_acc;
  logic [13:0] lat_frac_acc;
  logic [9:0]  lon_deg_acc;
  logic [6:0]  lon_min_acc;
  logic [13:0] lon_frac_acc;
  logic [7:0]  ns_letter;
  logic [7:0]  ew_letter;

  logic        accept;
  logic        at_limit;
  logic        is_digit;
  logic [3:0]  dig;
  logic [1:0]  lat_fidx;
  logic [1:0]  lon_fidx;

  function automatic logic [16:0] time_wt(input logic [3:0] c);
    logic [16:0] w;
    case (c)
      4'd0:    w = 17'd100000;
      4'd1:    w = 17'd10000;
      4'd2:    w = 17'd1000;
      4'd3:    w = 17'd100;
      4'd4:    w = 17'd10;
      4'd5:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  function automatic logic [9:0] frac_wt(input logic [1:0] i);
    logic [9:0] w;
    case (i)
      2'd0:    w = 10'd1000;
      2'd1:    w = 10'd100;
      2'd2:    w = 10'd10;
      default: w = 10'd1;
    endcase
    return w;
  endfunction

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign at_limit   = sentence_pos >= nrmc_pkg::POS_W'(nrmc_pkg::MAX_SENTENCE_LEN);
  assign is_digit   = rx_byte inside {[nrmc_pkg::CH_0:nrmc_pkg::CH_9]};
  assign dig        = is_digit ? rx_byte[3:0] : 4'd0;
  assign lat_fidx   = 2'(char_in_field - 4'd5);
  assign lon_fidx   = 2'(char_in_field - 4'd6);

  // A newline after a good header, within the length limit, past the header
  assign push = accept && (rx_byte == nrmc_pkg::CH_NL) && header_ok && !overflowed
                && !at_limit && (sentence_pos >= nrmc_pkg::POS_W'(6));

  always_comb begin
    push_rec.fix_valid = status_valid;
    push_rec.time_acc  = time_acc;
    push_rec.lat_deg   = lat_deg_acc;
    push_rec.lat_min   = lat_min_acc;
    push_rec.lat_frac  = lat_frac_acc;
    push_rec.lon_deg   = lon_deg_acc;
    push_rec.lon_min   = lon_min_acc;
    push_rec.lon_frac  = lon_frac_acc;
    push_rec.ns_letter = ns_letter;
    push_rec.ew_letter = ew_letter;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && (rx_byte inside {nrmc_pkg::CH_NL, nrmc_pkg::CH_DOLLAR}))) begin
      sentence_pos  <= '0;
      header_ok     <= 1'b0;
      overflowed    <= 1'b0;
      field_index   <= '0;
      char_in_field <= '0;
      time_acc      <= '0;
      status_valid  <= 1'b0;
      lat_deg_acc   <= '0;
      lat_min_acc   <= '0;
      lat_frac_acc  <= '0;
      lon_deg_acc   <= '0;
      lon_min_acc   <= '0;
      lon_frac_acc  <= '0;
      ns_letter     <= '0;
      ew_letter     <= '0;
      if (!rst && rx_byte == nrmc_pkg::CH_DOLLAR) begin
        header_ok    <= 1'b1;
        sentence_pos <= nrmc_pkg::POS_W'(1);
      end
    end else if (accept) begin
      if (at_limit) begin
        overflowed <= 1'b1;
      end else begin
        sentence_pos <= sentence_pos + nrmc_pkg::POS_W'(1);
      end
      if (!overflowed && !at_limit) begin
        if (sentence_pos == nrmc_pkg::POS_W'(0)) begin
          header_ok <= 1'b0;
        end else if (sentence_pos == nrmc_pkg::POS_W'(4)) begin
          header_ok <= header_ok && (rx_byte == nrmc_pkg::CH_M);
        end else if (sentence_pos == nrmc_pkg::POS_W'(5)) begin
          header_ok <= header_ok && (rx_byte == nrmc_pkg::CH_C);
        end

        if (rx_byte == nrmc_pkg::CH_COMMA) begin
          if (field_index != 3'd7) begin
            field_index <= field_index + 3'd1;
          end
          char_in_field <= '0;
        end else begin
          case (field_index)
            3'd1: begin
              if (char_in_field < 4'd6) begin
                time_acc <= time_acc + ({16'b0, dig} * {3'b0, time_wt(char_in_field)});
              end
            end
            3'd2: begin
              if (char_in_field == 4'd0) begin
                status_valid <= (rx_byte == nrmc_pkg::CH_A);
              end
            end
            3'd3: begin
              case (char_in_field)
                4'd0: lat_deg_acc <= lat_deg_acc + ({3'b0, dig} * 7'd10);
                4'd1: lat_deg_acc <= lat_deg_acc + {3'b0, dig};
                4'd2: lat_min_acc <= lat_min_acc + ({3'b0, dig} * 7'd10);
                4'd3: lat_min_acc <= lat_min_acc + {3'b0, dig};
                4'd5, 4'd6, 4'd7, 4'd8:
                  lat_frac_acc <= lat_frac_acc + ({10'b0, dig} * {4'b0, frac_wt(lat_fidx)});
                default: ;
              endcase
            end
            3'd4: begin
              if (char_in_field == 4'd0) begin
                ns_letter <= rx_byte;
              end
            end
            3'd5: begin
              case (char_in_field)
                4'd0: lon_deg_acc <= lon_deg_acc + ({6'b0, dig} * 10'd100);
                4'd1: lon_deg_acc <= lon_deg_acc + ({6'b0, dig} * 10'd10);
                4'd2: lon_deg_acc <= lon_deg_acc + {6'b0, dig};
                4'd3: lon_min_acc <= lon_min_acc + ({3'b0, dig} * 7'd10);
                4'd4: lon_min_acc <= lon_min_acc + {3'b0, dig};
                4'd6, 4'd7, 4'd8, 4'd9:
                  lon_frac_acc <= lon_frac_acc + ({10'b0, dig} * {4'b0, frac_wt(lon_fidx)});
                default: ;
              endcase
            end
            3'd6: begin
              if (char_in_field == 4'd0) begin
                ew_letter <= rx_byte;
              end
            end
            default: ;
          endcase
          if (char_in_field != 4'd15) begin
            char_in_field <= char_in_field + 4'd1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nrmc_queue.sv
// Small FIFO of fix records between the parser and the converter; the head
// record is read into a register on pop. Depends on nrmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrmc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  nrmc_pkg::fix_rec_t     push_rec,
  input  wire logic              pop,
  output nrmc_pkg::fix_rec_t     pop_rec,
  output logic                   full,
  output logic                   empty
);

  nrmc_pkg::fix_rec_t mem [nrmc_pkg::QUEUE_DEPTH];

  logic [nrmc_pkg::QPTR_W-1:0] wr_ptr;
  logic [nrmc_pkg::QPTR_W-1:0] rd_ptr;
  logic [nrmc_pkg::QCNT_W-1:0] count;

  assign full    = count == nrmc_pkg::QCNT_W'(nrmc_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;

  // pop needs a non-empty queue and push a non-full one, so the two
  // pointers never meet on a simultaneous read and write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
    if (pop) begin
      pop_rec <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + nrmc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + nrmc_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + nrmc_pkg::QCNT_W'(1);
        2'b01:   count <= count - nrmc_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nrmc_back.sv
// Converter: turns a fix record into signed 1e-7 degree coordinates in a
// three-stage pipeline (scale, divide by three, sum and sign) behind the
// registered queue read. Depends on nrmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrmc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  nrmc_pkg::fix_rec_t       q_rec,
  output logic                     q_pop,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output logic                     fix_valid,
  output logic [19:0]              utc_hhmmss,
  output logic signed [30:0]       latitude_e7,
  output logic signed [34:0]       longitude_e7,
  output logic [7:0]               north_south,
  output logic [7:0]               east_west
);

  typedef struct packed {
    logic        fix_valid;
    logic [19:0] time_acc;
    logic [7:0]  ns_letter;
    logic [7:0]  ew_letter;
    logic [29:0] lat_deg_e7;
    logic [19:0] lat_x;
    logic [33:0] lon_deg_e7;
    logic [19:0] lon_x;
  } scale_t;

  typedef struct packed {
    logic        fix_valid;
    logic [19:0] time_acc;
    logic [7:0]  ns_letter;
    logic [7:0]  ew_letter;
    logic [29:0] lat_deg_e7;
    logic [24:0] lat_q;
    logic [33:0] lon_deg_e7;
    logic [24:0] lon_q;
  } quot_t;

  logic   en;
  logic   v0;
  logic   v1;
  logic   v2;
  scale_t s1;
  quot_t  s2;

  logic [51:0] lat_prod;
  logic [51:0] lon_prod;
  logic [30:0] lat_mag;
  logic [34:0] lon_mag;

  // Whole pipeline moves unless the output register holds a stalled result
  assign en    = !(res_valid && res_stall);
  assign q_pop = en && !q_empty;

  assign lat_prod = {32'b0, s1.lat_x} * {20'b0, nrmc_pkg::DIV3_K};
  assign lon_prod = {32'b0, s1.lon_x} * {20'b0, nrmc_pkg::DIV3_K};

  assign lat_mag = {1'b0, s2.lat_deg_e7} + {6'b0, s2.lat_q};
  assign lon_mag = {1'b0, s2.lon_deg_e7} + {10'b0, s2.lon_q};

  // v0 marks the record sitting in the queue's read register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v0        <= q_pop;
      v1        <= v0;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.fix_valid  <= q_rec.fix_valid;
      s1.time_acc   <= q_rec.time_acc;
      s1.ns_letter  <= q_rec.ns_letter;
      s1.ew_letter  <= q_rec.ew_letter;
      s1.lat_deg_e7 <= {23'b0, q_rec.lat_deg} * 30'd10000000;
      s1.lat_x      <= ({13'b0, q_rec.lat_min} * 20'd10000) + {6'b0, q_rec.lat_frac};
      s1.lon_deg_e7 <= {24'b0, q_rec.lon_deg} * 34'd10000000;
      s1.lon_x      <= ({13'b0, q_rec.lon_min} * 20'd10000) + {6'b0, q_rec.lon_frac};

      s2.fix_valid  <= s1.fix_valid;
      s2.time_acc   <= s1.time_acc;
      s2.ns_letter  <= s1.ns_letter;
      s2.ew_letter  <= s1.ew_letter;
      s2.lat_deg_e7 <= s1.lat_deg_e7;
      s2.lon_deg_e7 <= s1.lon_deg_e7;
      s2.lat_q      <= lat_prod[nrmc_pkg::DIV3_SHIFT +: 25];
      s2.lon_q      <= lon_prod[nrmc_pkg::DIV3_SHIFT +: 25];

      fix_valid    <= s2.fix_valid;
      utc_hhmmss   <= s2.time_acc;
      north_south  <= s2.ns_letter;
      east_west    <= s2.ew_letter;
      latitude_e7  <= $signed((s2.ns_letter == nrmc_pkg::CH_S) ? (31'd0 - lat_mag) : lat_mag);
      longitude_e7 <= $signed((s2.ew_letter == nrmc_pkg::CH_W) ? (35'd0 - lon_mag) : lon_mag);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/nmea_rmc_position_parser_core.sv
// NMEA RMC position parser, top level. Depends on nrmc_pkg, nrmc_front,
// nrmc_queue and nrmc_back.
// Throughput: one byte per cycle while the four-entry fix queue has room.
// A record pushed on a newline passes the queue read, scale, divide and
// sign stages before it is offered. Reset (rst, synchronous, active
// high) clears the sentence state, queue pointers and pipeline valid bits.
`timescale 1ns / 1ps
`default_nettype none
module nmea_rmc_position_parser_core (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte channel
  input  wire logic         byte_valid,
  output logic              byte_stall,
  input  wire logic [7:0]   rx_byte,
  // result channel
  output logic              res_valid,
  input  wire logic         res_stall,
  output logic              fix_valid,
  output logic [19:0]       utc_hhmmss,
  output logic signed [30:0] latitude_e7,
  output logic signed [34:0] longitude_e7,
  output logic [7:0]        north_south,
  output logic [7:0]        east_west
);

  // Front: parses every byte, emits a fix record on a good RMC newline.
  // It only holds off the byte channel when the queue is full, which
  // happens only after the result channel has been stalled for a while.
  logic               push;
  nrmc_pkg::fix_rec_t push_rec;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  nrmc_pkg::fix_rec_t q_rec;

  nrmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  // Queue decouples the parser from the converter pipeline
  nrmc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: degrees*1e7 + floor(minutes*1e7/60), sign by hemisphere letter.
  // The last stage is the output register of the result channel.
  nrmc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .fix_valid    (fix_valid),
    .utc_hhmmss   (utc_hhmmss),
    .latitude_e7  (latitude_e7),
    .longitude_e7 (longitude_e7),
    .north_south  (north_south),
    .east_west    (east_west)
  );

endmodule
`default_nettype wire
